FILE: src/fla_pkg.sv
// shared types and constants for the free-list slot allocator
// depends on nothing; used by fla_engine and the core, not by fla_ram
package fla_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int ADDR_W     = $clog2(SLOT_COUNT);
    localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
    localparam int IDX_W      = 10;
    localparam int COUNT_W    = 11;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(SLOT_COUNT);

    typedef enum logic [1:0] {
        ST_GRANTED   = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_RELEASED  = 2'd2,
        ST_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ACQUIRE = 1'b0,
        KIND_RELEASE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        FLA_INIT,
        FLA_IDLE,
        FLA_FETCH
    } fla_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [LINK_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [IDX_W-1:0]   granted;
        logic [COUNT_W-1:0] count;
    } result_t;

endpackage

FILE: src/fla_ram.sv
// generic single-write, single-read synchronous ram with registered read
// depends on nothing
module fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/fla_engine.sv
// sequencer of the allocator: clearing pass, head and count registers,
// link memory requests; depends on fla_pkg
module fla_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      kind,
    input  logic [fla_pkg::IDX_W-1:0] slot_index,
    output logic                      in_stall,
    input  logic                      out_free,
    output logic                      res_load,
    output fla_pkg::result_t          res,
    output fla_pkg::mem_req_t         mem_req,
    input  logic [fla_pkg::LINK_W-1:0] mem_rdata
);

    fla_pkg::fla_state_t              state_reg, state_next;
    logic [fla_pkg::ADDR_W-1:0]       init_cnt_reg, init_cnt_next;
    logic [fla_pkg::LINK_W-1:0]       head_reg, head_next;
    logic [fla_pkg::COUNT_W-1:0]      used_reg, used_next;
    logic [fla_pkg::IDX_W-1:0]        grant_reg, grant_next;

    logic head_empty;
    logic idx_bad;
    logic accept;

    assign head_empty = (head_reg >= fla_pkg::NIL_LINK);
    assign idx_bad    = ({1'b0, slot_index} >= fla_pkg::LINK_W'(fla_pkg::SLOT_COUNT));

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fla_pkg::FLA_INIT;
            init_cnt_reg <= '0;
            head_reg     <= '0;
            used_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            init_cnt_reg <= init_cnt_next;
            head_reg     <= head_next;
            used_reg     <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grant_reg <= grant_next;
    end

    // next state, memory requests and result beat
    always_comb
    begin
        state_next    = state_reg;
        init_cnt_next = init_cnt_reg;
        head_next     = head_reg;
        used_next     = used_reg;
        grant_next    = grant_reg;
        in_stall      = 1'b1;
        accept        = 1'b0;
        res_load      = 1'b0;
        res.status    = fla_pkg::ST_GRANTED;
        res.granted   = '0;
        res.count     = used_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = head_reg[fla_pkg::ADDR_W-1:0];
        mem_req.wdata = head_reg;
        mem_req.raddr = head_reg[fla_pkg::ADDR_W-1:0];

        unique case (state_reg)
            fla_pkg::FLA_INIT:
            begin
                // every entry links to the next, the last one to nil
                mem_req.we    = 1'b1;
                mem_req.waddr = init_cnt_reg;
                mem_req.wdata = fla_pkg::LINK_W'(init_cnt_reg) + fla_pkg::LINK_W'(1);
                init_cnt_next = init_cnt_reg + fla_pkg::ADDR_W'(1);
                if (init_cnt_reg == fla_pkg::ADDR_W'(fla_pkg::SLOT_COUNT - 1))
                begin
                    state_next = fla_pkg::FLA_IDLE;
                end
            end

            fla_pkg::FLA_IDLE:
            begin
                in_stall = !out_free;
                accept   = in_valid && out_free;
                if (accept)
                begin
                    if (kind == fla_pkg::KIND_ACQUIRE)
                    begin
                        if (head_empty)
                        begin
                            res_load   = 1'b1;
                            res.status = fla_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            // link of the head arrives next cycle
                            grant_next = fla_pkg::IDX_W'(head_reg);
                            state_next = fla_pkg::FLA_FETCH;
                        end
                    end
                    else if (idx_bad)
                    begin
                        res_load   = 1'b1;
                        res.status = fla_pkg::ST_BAD_INDEX;
                    end
                    else
                    begin
                        // push the slot as the new head
                        mem_req.we    = 1'b1;
                        mem_req.waddr = slot_index[fla_pkg::ADDR_W-1:0];
                        mem_req.wdata = head_reg;
                        head_next     = fla_pkg::LINK_W'(slot_index);
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - fla_pkg::COUNT_W'(1);
                        end
                        res_load   = 1'b1;
                        res.status = fla_pkg::ST_RELEASED;
                        res.count  = used_next;
                    end
                end
            end

            fla_pkg::FLA_FETCH:
            begin
                // pop: head takes the link read from memory
                head_next = mem_rdata;
                if (used_reg < fla_pkg::COUNT_W'(fla_pkg::SLOT_COUNT))
                begin
                    used_next = used_reg + fla_pkg::COUNT_W'(1);
                end
                res_load    = 1'b1;
                res.status  = fla_pkg::ST_GRANTED;
                res.granted = grant_reg;
                res.count   = used_next;
                state_next  = fla_pkg::FLA_IDLE;
            end

            default:
            begin
                state_next = fla_pkg::FLA_IDLE;
            end
        endcase
    end

    // checks
    a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fla_pkg::FLA_INIT) |-> in_stall)
        else $error("input accepted during clearing pass");

    a_acquire_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == fla_pkg::KIND_ACQUIRE) && !head_empty)
        |=> (res_load && (res.status == fla_pkg::ST_GRANTED)))
        else $error("acquire did not grant in the following cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= fla_pkg::COUNT_W'(fla_pkg::SLOT_COUNT))
        else $error("slot count above pool size");

endmodule

FILE: src/free_list_slot_allocator_core.sv
// Free-list slot allocator: a pool of SLOT_COUNT slots kept as a linked free
// list in one synchronous link memory, with head and in-use count registers.
// After reset a clearing pass writes the initial links, with input stalled.
// An acquire of a free slot reads the head's link from the link memory in a
// fetch state; a release, an empty acquire and a bad release load the result
// beat in the cycle they are taken. Every input beat gives exactly one result
// beat, held in an output register; the next input beat is taken in the cycle
// that the waiting result leaves, and a stalled result stalls the input.
// Depends on fla_pkg, fla_engine and fla_ram.
module free_list_slot_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [fla_pkg::IDX_W-1:0]   slot_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic [fla_pkg::IDX_W-1:0]   granted_index,
    output logic [fla_pkg::COUNT_W-1:0] slots_in_use
);

    fla_pkg::mem_req_t               mem_req;
    logic [fla_pkg::LINK_W-1:0]      mem_rdata;
    fla_pkg::result_t                res;
    logic                            res_load;
    logic                            out_free;
    logic                            out_valid_reg;
    fla_pkg::result_t                out_reg;

    assign out_free = !out_valid_reg || !out_stall;

    fla_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .slot_index (slot_index),
        .in_stall   (in_stall),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    fla_ram #(
        .WIDTH (fla_pkg::LINK_W),
        .DEPTH (fla_pkg::SLOT_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign granted_index = out_reg.granted;
    assign slots_in_use  = out_reg.count;

    // checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> out_free)
        else $error("result beat overwrote a waiting beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_reg)))
        else $error("stalled result beat changed or dropped");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while result beat is stalled");

endmodule
